@@ rtl/blarp_pkg.sv @@
`default_nettype none
package blarp_pkg;

	localparam int ADDR_BYTES  = 6;
	localparam int UUID_MAX    = 16;
	localparam logic [3:0] UNKNOWN_SAT = 4'd15;

	localparam logic [7:0] KIND_FLAGS     = 8'h01;
	localparam logic [7:0] KIND_UUID_LO   = 8'h02;
	localparam logic [7:0] KIND_UUID_HI   = 8'h07;
	localparam logic [7:0] KIND_NAME      = 8'h09;
	localparam logic [7:0] KIND_MANUF     = 8'hFF;

	typedef enum logic [3:0] {
		PH_WAIT,
		PH_EVTYPE,
		PH_ADDRTYPE,
		PH_ADDR,
		PH_DATALEN,
		PH_ADLEN,
		PH_ADTYPE,
		PH_ADVALUE,
		PH_RSSI
	} phase_t;

	typedef enum logic {
		REC_SUMMARY = 1'b0,
		REC_NAME    = 1'b1
	} rec_kind_t;

	typedef struct packed {
		logic [3:0]  unknown_count;
		logic [15:0] company_id;
		logic [4:0]  uuid_length;
		logic [63:0] uuid_high;
		logic [63:0] uuid_low;
		logic [7:0]  adv_flags;
		logic [47:0] device_address;
		logic [7:0]  address_type;
	} summary_t;

	typedef struct packed {
		logic [6:0]         pad;
		logic [7:0]         name_byte;
		logic [3:0]         unknown_count;
		logic signed [7:0]  rssi_dbm;
		logic [15:0]        company_id;
		logic [4:0]         uuid_length;
		logic [63:0]        uuid_high;
		logic [63:0]        uuid_low;
		logic [7:0]         adv_flags;
		logic [47:0]        device_address;
		logic [7:0]         address_type;
	} out_data_t;

endpackage
`default_nettype wire

@@ rtl/blarp_ram.sv @@
`default_nettype none
module blarp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/blarp_parse.sv @@
`default_nettype none
module blarp_parse #(
	parameter int NAME_MAX = 32,
	localparam int AW  = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1,
	localparam int NCW = $clog2(NAME_MAX + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire logic [7:0]          data_byte,
	input  wire logic                report_start,
	output logic                     at_rssi,
	output blarp_pkg::summary_t      summary,
	output logic [NCW-1:0]           name_count,
	output logic                     name_we,
	output logic [AW-1:0]            name_waddr,
	output logic [7:0]               name_wdata
);

	blarp_pkg::phase_t phase_q, phase_d;

	logic [2:0]       byte_idx_q;
	logic [7:0]       data_rem_q;
	logic [7:0]       ad_rem_q;
	logic [7:0]       ad_kind_q;
	logic [7:0]       addr_type_q;
	logic [5:0][7:0]  addr_q;
	logic [7:0]       flags_q;
	logic [15:0][7:0] uuid_q;
	logic [4:0]       uuid_cnt_q;
	logic [15:0]      company_q;
	logic [NCW-1:0]   name_cnt_q;
	logic [3:0]       unknown_q;

	logic [8:0] ad_len_p1;
	logic       type_is_uuid;
	logic       data_done;

	assign ad_len_p1    = {1'b0, data_byte} + 9'd1;
	assign type_is_uuid = (data_byte >= blarp_pkg::KIND_UUID_LO)
			&& (data_byte <= blarp_pkg::KIND_UUID_HI);
	assign data_done    = (data_rem_q == 8'd0);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			if (report_start) begin
				phase_d = blarp_pkg::PH_EVTYPE;
			end else begin
				case (phase_q)
				blarp_pkg::PH_EVTYPE:   phase_d = blarp_pkg::PH_ADDRTYPE;
				blarp_pkg::PH_ADDRTYPE: phase_d = blarp_pkg::PH_ADDR;
				blarp_pkg::PH_ADDR: begin
					if (byte_idx_q == 3'(blarp_pkg::ADDR_BYTES - 1))
						phase_d = blarp_pkg::PH_DATALEN;
				end
				blarp_pkg::PH_DATALEN, blarp_pkg::PH_ADLEN: begin
					phase_d = (data_byte == 8'd0) ? blarp_pkg::PH_RSSI
							: (phase_q == blarp_pkg::PH_DATALEN)
							? blarp_pkg::PH_ADLEN : blarp_pkg::PH_ADTYPE;
				end
				blarp_pkg::PH_ADTYPE, blarp_pkg::PH_ADVALUE: begin
					if (ad_rem_q == 8'd1)
						phase_d = data_done ? blarp_pkg::PH_RSSI : blarp_pkg::PH_ADLEN;
					else
						phase_d = blarp_pkg::PH_ADVALUE;
				end
				blarp_pkg::PH_RSSI:     phase_d = blarp_pkg::PH_WAIT;
				default:                phase_d = blarp_pkg::PH_WAIT;
				endcase
			end
		end
	end

	// outputs
	always_comb begin
		at_rssi    = (phase_q == blarp_pkg::PH_RSSI);
		name_we    = fire && !report_start && (phase_q == blarp_pkg::PH_ADVALUE)
				&& (ad_kind_q == blarp_pkg::KIND_NAME)
				&& (name_cnt_q < NCW'(NAME_MAX));
		name_waddr = name_cnt_q[AW-1:0];
		name_wdata = data_byte;
		summary.address_type   = addr_type_q;
		summary.device_address = addr_q;
		summary.adv_flags      = flags_q;
		summary.uuid_low       = uuid_q[7:0];
		summary.uuid_high      = uuid_q[15:8];
		summary.uuid_length    = uuid_cnt_q;
		summary.company_id     = company_q;
		summary.unknown_count  = unknown_q;
		name_count             = name_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= blarp_pkg::PH_WAIT;
			byte_idx_q  <= '0;
			data_rem_q  <= '0;
			ad_rem_q    <= '0;
			ad_kind_q   <= '0;
			addr_type_q <= '0;
			addr_q      <= '0;
			flags_q     <= '0;
			uuid_q      <= '0;
			uuid_cnt_q  <= '0;
			company_q   <= '0;
			name_cnt_q  <= '0;
			unknown_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (fire) begin
				if (report_start) begin
					byte_idx_q  <= '0;
					data_rem_q  <= '0;
					ad_rem_q    <= '0;
					ad_kind_q   <= '0;
					addr_type_q <= '0;
					addr_q      <= '0;
					flags_q     <= '0;
					uuid_q      <= '0;
					uuid_cnt_q  <= '0;
					company_q   <= '0;
					name_cnt_q  <= '0;
					unknown_q   <= '0;
				end else begin
					case (phase_q)
					blarp_pkg::PH_ADDRTYPE: begin
						addr_type_q <= data_byte;
						byte_idx_q  <= '0;
					end
					blarp_pkg::PH_ADDR: begin
						if (byte_idx_q < 3'(blarp_pkg::ADDR_BYTES))
							addr_q[byte_idx_q] <= data_byte;
						byte_idx_q <= byte_idx_q + 3'd1;
					end
					blarp_pkg::PH_DATALEN: begin
						data_rem_q <= data_byte;
					end
					blarp_pkg::PH_ADLEN: begin
						if (data_byte == 8'd0) begin
							data_rem_q <= '0;
						end else begin
							ad_rem_q <= data_byte;
							// structure overruns the data: parse it, then end
							if (ad_len_p1 >= {1'b0, data_rem_q})
								data_rem_q <= '0;
							else
								data_rem_q <= data_rem_q - ad_len_p1[7:0];
						end
					end
					blarp_pkg::PH_ADTYPE: begin
						ad_kind_q  <= data_byte;
						byte_idx_q <= '0;
						ad_rem_q   <= ad_rem_q - 8'd1;
						if (type_is_uuid) begin
							uuid_q     <= '0;
							uuid_cnt_q <= '0;
						end else if (data_byte == blarp_pkg::KIND_NAME) begin
							name_cnt_q <= '0;
						end else if (data_byte == blarp_pkg::KIND_MANUF) begin
							company_q <= '0;
						end else if (data_byte != blarp_pkg::KIND_FLAGS) begin
							if (unknown_q != blarp_pkg::UNKNOWN_SAT)
								unknown_q <= unknown_q + 4'd1;
						end
					end
					blarp_pkg::PH_ADVALUE: begin
						ad_rem_q <= ad_rem_q - 8'd1;
						if (byte_idx_q != 3'd7)
							byte_idx_q <= byte_idx_q + 3'd1;
						if (ad_kind_q == blarp_pkg::KIND_FLAGS) begin
							if (byte_idx_q == 3'd0)
								flags_q <= data_byte;
						end else if ((ad_kind_q >= blarp_pkg::KIND_UUID_LO)
								&& (ad_kind_q <= blarp_pkg::KIND_UUID_HI)) begin
							if (uuid_cnt_q < 5'(blarp_pkg::UUID_MAX)) begin
								uuid_q[uuid_cnt_q[3:0]] <= data_byte;
								uuid_cnt_q <= uuid_cnt_q + 5'd1;
							end
						end else if (ad_kind_q == blarp_pkg::KIND_NAME) begin
							if (name_cnt_q < NCW'(NAME_MAX))
								name_cnt_q <= name_cnt_q + NCW'(1);
						end else if (ad_kind_q == blarp_pkg::KIND_MANUF) begin
							if (byte_idx_q == 3'd0)
								company_q[7:0] <= data_byte;
							else if (byte_idx_q == 3'd1)
								company_q[15:8] <= data_byte;
						end
					end
					default: begin
					end
					endcase
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/blarp_emit.sv @@
`default_nettype none
module blarp_emit #(
	parameter int NAME_MAX = 32,
	localparam int AW  = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1,
	localparam int NCW = $clog2(NAME_MAX + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire blarp_pkg::summary_t summary,
	input  wire logic [NCW-1:0]      name_count,
	input  wire logic [7:0]          rssi,
	output logic                     busy,
	output logic [AW-1:0]            name_raddr,
	input  wire logic [7:0]          name_rdata,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output blarp_pkg::out_data_t     out_data,
	output blarp_pkg::rec_kind_t     out_kind,
	output logic                     out_last
);

	logic                 valid_q;
	blarp_pkg::rec_kind_t kind_q;
	logic [NCW-1:0]       cnt_q;
	logic [AW-1:0]        idx_q;
	blarp_pkg::summary_t  sum_q;
	logic [7:0]           rssi_q;

	logic fire;
	logic name_last;

	assign fire      = valid_q && out_ready;
	assign name_last = ((NCW'(idx_q) + NCW'(1)) == cnt_q);

	// read address runs one ahead so the RAM output matches the shown beat
	assign name_raddr = (fire && (kind_q == blarp_pkg::REC_NAME) && !name_last)
			? idx_q + AW'(1) : idx_q;

	assign busy      = valid_q && ((kind_q == blarp_pkg::REC_NAME) || (cnt_q != '0));
	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_last  = (kind_q == blarp_pkg::REC_NAME) ? name_last : (cnt_q == '0);

	always_comb begin
		out_data = '0;
		if (kind_q == blarp_pkg::REC_NAME) begin
			out_data.name_byte = name_rdata;
		end else begin
			out_data.address_type   = sum_q.address_type;
			out_data.device_address = sum_q.device_address;
			out_data.adv_flags      = sum_q.adv_flags;
			out_data.uuid_low       = sum_q.uuid_low;
			out_data.uuid_high      = sum_q.uuid_high;
			out_data.uuid_length    = sum_q.uuid_length;
			out_data.company_id     = sum_q.company_id;
			out_data.rssi_dbm       = rssi_q;
			out_data.unknown_count  = sum_q.unknown_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			kind_q  <= blarp_pkg::REC_SUMMARY;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			kind_q  <= blarp_pkg::REC_SUMMARY;
			cnt_q   <= name_count;
			idx_q   <= '0;
		end else if (fire) begin
			if (kind_q == blarp_pkg::REC_SUMMARY) begin
				if (cnt_q != '0)
					kind_q <= blarp_pkg::REC_NAME;
				else
					valid_q <= 1'b0;
			end else if (name_last) begin
				valid_q <= 1'b0;
				kind_q  <= blarp_pkg::REC_SUMMARY;
			end else begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sum_q  <= summary;
			rssi_q <= rssi;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ble_adv_report_parser.sv @@
// Parses one LE advertising report per run, one byte per beat from the
// report-count byte on (report_start on tuser restarts it). The RSSI byte yields
// a summary record, then one record per captured name byte, one output beat per
// cycle while m_tready is high, from the name RAM read port: 1 + name length
// beats. Input is held off while name records are pending, and an RSSI byte
// waits while the previous summary is still in the output register.
`default_nettype none
module ble_adv_report_parser #(
	parameter int NAME_MAX = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,  // data_byte
	input  wire logic         s_tuser,  // report_start
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// address_type, device_address, adv_flags, uuid_low, uuid_high, uuid_length,
	// company_id, rssi_dbm, unknown_count, name_byte, zero pad
	output logic [239:0]      m_tdata,
	output logic              m_tuser,  // record_kind
	output logic              m_tlast   // last
);

	localparam int AW  = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
	localparam int NCW = $clog2(NAME_MAX + 1);

	logic                 in_fire;
	logic                 at_rssi;
	logic                 busy;
	blarp_pkg::summary_t  summary;
	logic [NCW-1:0]       name_count;
	logic                 name_we;
	logic [AW-1:0]        name_waddr;
	logic [7:0]           name_wdata;
	logic [AW-1:0]        name_raddr;
	logic [7:0]           name_rdata;
	blarp_pkg::out_data_t out_data;
	blarp_pkg::rec_kind_t out_kind;

	assign s_tready = !busy && !(m_tvalid && at_rssi);
	assign in_fire  = s_tvalid && s_tready;

	blarp_parse #(.NAME_MAX(NAME_MAX)) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (in_fire),
		.data_byte    (s_tdata),
		.report_start (s_tuser),
		.at_rssi      (at_rssi),
		.summary      (summary),
		.name_count   (name_count),
		.name_we      (name_we),
		.name_waddr   (name_waddr),
		.name_wdata   (name_wdata)
	);

	blarp_ram #(.WIDTH(8), .DEPTH(NAME_MAX)) u_name_ram (
		.clk   (clk),
		.we    (name_we),
		.waddr (name_waddr),
		.wdata (name_wdata),
		.raddr (name_raddr),
		.rdata (name_rdata)
	);

	blarp_emit #(.NAME_MAX(NAME_MAX)) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (in_fire && at_rssi && !s_tuser),
		.summary    (summary),
		.name_count (name_count),
		.rssi       (s_tdata),
		.busy       (busy),
		.name_raddr (name_raddr),
		.name_rdata (name_rdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_data),
		.out_kind   (out_kind),
		.out_last   (m_tlast)
	);

	assign m_tdata = out_data;
	assign m_tuser = out_kind;

endmodule
`default_nettype wire

@@ tb/ble_adv_report_parser_tb.sv @@
module ble_adv_report_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import blarp_pkg::*;

	localparam int NAME_MAX = 32;
	localparam int LIMIT = 300000;
	localparam int NO_CUT = 1 << 30;

	typedef struct {
		logic [7:0] data;
		logic       start;
	} in_beat_t;

	typedef struct {
		rec_kind_t kind;
		out_data_t d;
		logic      last;
	} record_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [239:0] m_tdata;
	logic         m_tuser;
	logic         m_tlast;

	ble_adv_report_parser #(.NAME_MAX(NAME_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	in_beat_t byte_q[$];
	record_t  record_q[$];
	int send_idle = 36;
	int recv_idle = 60;
	int errors = 0;
	int cycles = 0;
	int bytes_queued = 0;
	int rep_len = 0;
	int rep_cut = NO_CUT;
	int reports_seen = 0;
	int summaries_seen = 0;
	int names_seen = 0;

	// parser state as predicted
	phase_t      ph = PH_WAIT;
	logic [2:0]  bidx;
	logic [8:0]  dremain;
	logic [7:0]  adrem;
	logic [7:0]  adkind;
	logic [7:0]  atype;
	logic [47:0] addr;
	logic [7:0]  flags;
	logic [63:0] uuid_w [2];
	logic [4:0]  ucnt;
	logic [15:0] company;
	logic [7:0]  name_buf [NAME_MAX];
	logic [6:0]  ncnt;
	logic [3:0]  unk;

	task automatic clear_capture();
		bidx = '0; dremain = '0; adrem = '0; adkind = '0;
		atype = '0; addr = '0; flags = '0;
		uuid_w[0] = '0; uuid_w[1] = '0; ucnt = '0;
		company = '0; ncnt = '0; unk = '0;
	endtask

	task automatic close_struct();
		ph = (dremain == 0) ? PH_RSSI : PH_ADLEN;
	endtask

	task automatic take_value(input logic [7:0] b);
		if (adkind == KIND_FLAGS) begin
			if (bidx == 0)
				flags = b;
		end else if (adkind >= KIND_UUID_LO && adkind <= KIND_UUID_HI) begin
			if (ucnt < UUID_MAX) begin
				uuid_w[ucnt[3]][ucnt[2:0]*8 +: 8] = b;
				ucnt++;
			end
		end else if (adkind == KIND_NAME) begin
			if (ncnt < NAME_MAX) begin
				name_buf[ncnt] = b;
				ncnt++;
			end
		end else if (adkind == KIND_MANUF) begin
			if (bidx == 0)
				company[7:0] = b;
			else if (bidx == 1)
				company[15:8] = b;
		end
		if (bidx < 7)
			bidx++;
	endtask

	task automatic predict_records(input logic [7:0] b, input logic st);
		record_t r;
		logic [8:0] span;
		if (st) begin
			clear_capture();
			ph = PH_EVTYPE;
			reports_seen++;
			return;
		end
		case (ph)
			PH_EVTYPE: ph = PH_ADDRTYPE;
			PH_ADDRTYPE: begin
				atype = b;
				bidx = '0;
				ph = PH_ADDR;
			end
			PH_ADDR: begin
				addr[bidx*8 +: 8] = b;
				bidx++;
				if (bidx >= ADDR_BYTES)
					ph = PH_DATALEN;
			end
			PH_DATALEN: begin
				dremain = {1'b0, b};
				ph = (b == 0) ? PH_RSSI : PH_ADLEN;
			end
			PH_ADLEN: begin
				if (b == 0) begin
					dremain = '0;
					ph = PH_RSSI;
				end else begin
					span = {1'b0, b} + 9'd1;
					adrem = b;
					dremain = (span >= dremain) ? 9'd0 : dremain - span;
					ph = PH_ADTYPE;
				end
			end
			PH_ADTYPE: begin
				adkind = b;
				bidx = '0;
				adrem = adrem - 8'd1;
				if (b >= KIND_UUID_LO && b <= KIND_UUID_HI) begin
					uuid_w[0] = '0; uuid_w[1] = '0; ucnt = '0;
				end else if (b == KIND_NAME) begin
					ncnt = '0;
				end else if (b == KIND_MANUF) begin
					company = '0;
				end else if (b != KIND_FLAGS && unk != UNKNOWN_SAT) begin
					unk++;
				end
				if (adrem == 0)
					close_struct();
				else
					ph = PH_ADVALUE;
			end
			PH_ADVALUE: begin
				take_value(b);
				adrem = adrem - 8'd1;
				if (adrem == 0)
					close_struct();
			end
			PH_RSSI: begin
				r.kind = REC_SUMMARY;
				r.d = '0;
				r.d.address_type = atype;
				r.d.device_address = addr;
				r.d.adv_flags = flags;
				r.d.uuid_low = uuid_w[0];
				r.d.uuid_high = uuid_w[1];
				r.d.uuid_length = ucnt;
				r.d.company_id = company;
				r.d.rssi_dbm = b;
				r.d.unknown_count = unk;
				r.last = (ncnt == 0);
				record_q.push_back(r);
				for (int k = 0; k < ncnt; k++) begin
					r.kind = REC_NAME;
					r.d = '0;
					r.d.name_byte = name_buf[k];
					r.last = (k + 1 == ncnt);
					record_q.push_back(r);
				end
				ph = PH_WAIT;
			end
			default: ;
		endcase
	endtask

	task automatic flag_error(input string what, input logic [63:0] want, input logic [63:0] got);
		errors++;
		if (errors <= 10)
			$display("mismatch %s: expected %h, got %h", what, want, got);
	endtask

	task automatic chk(input string what, input logic [63:0] want, input logic [63:0] got);
		if (want !== got)
			flag_error(what, want, got);
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				void'(byte_q.pop_front());
			if (!s_tvalid || s_tready) begin
				if (byte_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					s_tvalid <= 1'b1;
					s_tdata <= byte_q[0].data;
					s_tuser <= byte_q[0].start;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// monitor and predictor
	always @(posedge clk) begin : monitor
		out_data_t got;
		record_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (record_q.size() == 0) begin
					flag_error("unexpected beat", 64'd0, {63'd0, m_tuser});
				end else begin
					want = record_q.pop_front();
					chk("record_kind", want.kind, m_tuser);
					chk("last", want.last, m_tlast);
					chk("address_type", want.d.address_type, got.address_type);
					chk("device_address", want.d.device_address, got.device_address);
					chk("adv_flags", want.d.adv_flags, got.adv_flags);
					chk("uuid_low", want.d.uuid_low, got.uuid_low);
					chk("uuid_high", want.d.uuid_high, got.uuid_high);
					chk("uuid_length", want.d.uuid_length, got.uuid_length);
					chk("company_id", want.d.company_id, got.company_id);
					chk("rssi_dbm", want.d.rssi_dbm, got.rssi_dbm);
					chk("unknown_count", want.d.unknown_count, got.unknown_count);
					chk("name_byte", want.d.name_byte, got.name_byte);
				end
				if (m_tuser == REC_NAME)
					names_seen++;
				else
					summaries_seen++;
			end
			if (s_tvalid && s_tready)
				predict_records(s_tdata, s_tuser);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send(input logic [7:0] b, input logic st = 1'b0);
		in_beat_t t;
		if (rep_len < rep_cut) begin
			t.data = b;
			t.start = st;
			byte_q.push_back(t);
			bytes_queued++;
		end
		rep_len++;
	endtask

	task automatic header(input logic [7:0] cnt, input logic [7:0] at, input logic [47:0] a);
		rep_len = 0;
		send(cnt, 1'b1);
		send(8'($urandom_range(255)));
		send(at);
		for (int i = 0; i < ADDR_BYTES; i++)
			send(a[i*8 +: 8]);
	endtask

	task automatic ad_struct(input logic [7:0] kind, input int n);
		send(8'(n + 1));
		send(kind);
		repeat (n)
			send(8'($urandom_range(255)));
	endtask

	task automatic random_report();
		logic [7:0] kinds [8];
		int lens [8];
		int nk, total, dl, r, want_nk;
		logic [7:0] kd;
		int ln;
		nk = 0;
		total = 0;
		want_nk = $urandom_range(6);
		while (nk < want_nk) begin
			r = $urandom_range(99);
			if (r < 12) begin
				kd = KIND_FLAGS;
				ln = $urandom_range(2);
			end else if (r < 36) begin
				kd = 8'($urandom_range(KIND_UUID_HI, KIND_UUID_LO));
				ln = ($urandom_range(9) == 0) ? $urandom_range(24, 17) : $urandom_range(16);
			end else if (r < 56) begin
				kd = KIND_NAME;
				ln = ($urandom_range(9) == 0) ? $urandom_range(40, 30) : $urandom_range(10);
			end else if (r < 70) begin
				kd = KIND_MANUF;
				ln = $urandom_range(5);
			end else if (r < 92) begin
				kd = 8'($urandom_range(255));
				ln = $urandom_range(4);
			end else begin
				kd = 8'h00;
				ln = -1;
			end
			if (total + ln + 2 > 255)
				break;
			kinds[nk] = kd;
			lens[nk] = ln;
			total += ln + 2;
			nk++;
		end
		r = $urandom_range(99);
		if (r < 80)
			dl = total;
		else if (r < 90)
			dl = $urandom_range(total);
		else
			dl = (total + 6 > 255) ? 255 : total + $urandom_range(6, 1);
		rep_cut = NO_CUT;
		if ($urandom_range(99) < 10)
			repeat ($urandom_range(3, 1))
				send(8'($urandom_range(255)));
		if ($urandom_range(99) < 8)
			rep_cut = $urandom_range(10 + total, 1);
		header(8'($urandom_range(255)), 8'($urandom_range(255)),
			{16'($urandom), 32'($urandom)});
		send(8'(dl));
		for (int i = 0; i < nk; i++) begin
			if (lens[i] < 0)
				send(8'h00);
			else
				ad_struct(kinds[i], lens[i]);
		end
		send(8'($urandom_range(255)));
		rep_cut = NO_CUT;
	endtask

	task automatic wait_drained();
		while (byte_q.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	initial begin
		int mark;
		clear_capture();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// stray bytes before any report
		send(8'h00);
		send(8'hFF);
		// all-ones header, every known type, extra flags byte, type-only unknown
		header(8'hFF, 8'hFF, '1);
		send(8'd17);
		send(8'd3); send(KIND_FLAGS); send(8'hA5); send(8'h5A);
		ad_struct(KIND_UUID_HI, 2);
		ad_struct(KIND_NAME, 2);
		send(8'd3); send(KIND_MANUF); send(8'h34); send(8'h12);
		ad_struct(8'h16, 0);
		send(8'h80);
		// no advertising data at all
		header(8'h00, 8'h00, '0);
		send(8'h00);
		send(8'h7F);
		// zero AD length ends the data early
		header(8'h01, 8'h01, 48'h0123_4567_89AB);
		send(8'd10);
		send(8'h00);
		send(8'h00);
		// restart mid-address, then empty flags and an overrunning name
		header(8'h01, 8'h00, 48'h0000_0000_BBAA);
		rep_len = 0;
		byte_q = byte_q[0:$-4];
		bytes_queued -= 4;
		header(8'h02, 8'h01, 48'hC0FF_EE00_1234);
		send(8'd4);
		ad_struct(KIND_FLAGS, 0);
		ad_struct(KIND_NAME, 3);
		send(8'hC3);
		// long UUID, replaced names, truncated name, short manufacturer data,
		// unknown types past saturation
		header(8'h01, 8'h01, 48'h1122_3344_5566);
		send(8'd98);
		ad_struct(8'h03, 20);
		ad_struct(KIND_NAME, 1);
		ad_struct(KIND_NAME, 36);
		ad_struct(KIND_MANUF, 1);
		repeat (16)
			ad_struct(8'h20, 0);
		send(8'($urandom_range(255)));

		for (int p = 0; p < 3; p++) begin
			if (p == 1) begin
				send_idle = 60;
				recv_idle = 36;
			end else if (p == 2) begin
				send_idle = 0;
				recv_idle = 0;
			end
			mark = bytes_queued;
			while (bytes_queued - mark < 65)
				random_report();
			wait_drained();
		end

		while (record_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		$display("%0d bytes in %0d reports sent; %0d summary and %0d name records checked",
			bytes_queued, reports_seen, summaries_seen, names_seen);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches", errors);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/blarp_pkg.sv
rtl/blarp_ram.sv
rtl/blarp_parse.sv
rtl/blarp_emit.sv
rtl/ble_adv_report_parser.sv
tb/ble_adv_report_parser_tb.sv
